>>> src/rbsi_pkg.sv
// shared constants and types for the ray/box slab intersection unit
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 32;
  localparam int H_W           = 31;
  localparam int IDX_W         = 2;
  localparam int LANES         = 6;

  localparam logic [H_W-1:0] H_RESET = 31'd32768;

  typedef logic signed [Q_W-1:0] fx_t;

  typedef enum logic [IDX_W-1:0] {
    REG_HALF_W = 2'd0,
    REG_HALF_H = 2'd1,
    REG_HALF_L = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // per-ray data that rides alongside the dividers
  typedef struct packed {
    logic [2:0][Q_W-1:0] o;
    logic [2:0][Q_W-1:0] d;
    logic [2:0]          fin;
    logic                zmiss;
    logic [LANES-1:0]    qneg;
  } side_t;

endpackage

`default_nettype wire

>>> src/rbsi_in_if.sv
// ray request channel
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_in_if;
  import rbsi_pkg::*;
  logic valid;
  logic ready;
  fx_t  origin_x;
  fx_t  origin_y;
  fx_t  origin_z;
  fx_t  dir_x;
  fx_t  dir_y;
  fx_t  dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

`default_nettype wire

>>> src/rbsi_out_if.sv
// intersection result channel
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_out_if;
  import rbsi_pkg::*;
  logic           valid;
  logic           ready;
  logic           hit;
  logic [H_W-1:0] distance;
  fx_t            point_x;
  fx_t            point_y;
  fx_t            point_z;
  logic [1:0]     normal_axis;
  logic           normal_negative;
  logic           from_inside;

  modport source (output valid, hit, distance, point_x, point_y, point_z, normal_axis,
                         normal_negative, from_inside,
                  input ready);
  modport sink   (input valid, hit, distance, point_x, point_y, point_z, normal_axis,
                        normal_negative, from_inside,
                  output ready);
endinterface

`default_nettype wire

>>> src/rbsi_cfg_if.sv
// register write channel
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_cfg_if;
  import rbsi_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [Q_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/rbsi_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quo_o
);

  // numerator bits shift out the top while quotient bits shift in below
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k]  <= {nq_in[NUM_W-2:0], ge};
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_r[NUM_W-1];

endmodule

`default_nettype wire

>>> src/ray_box_slab_intersect_unit.sv
// ray against origin-centered box, slab method, fully pipelined
//
//   port    dir  handshake    carries
//   in_ch   in   valid/ready  ray origin and direction
//   out_ch  out  valid/ready  hit, distance, hit point, face normal
//   cfg_ch  in   valid/ready  box half extents (index 0..2)
//
// one ray per cycle while the output is not stalled; the pipe holds six
// bit-serial-in-space dividers of 32 + FRAC_BITS stages each (Q16.16 by default).
// synchronous active-low reset clears valid bits and sets each half extent to 0.5.
// a stall at the output freezes the whole pipe; in_ch.ready follows it.
// cfg_ch is always ready; a write takes effect in the following cycle.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_unit
  import rbsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rbsi_in_if.sink     in_ch,
  rbsi_out_if.source  out_ch,
  rbsi_cfg_if.sink    cfg_ch
);

  localparam int NUM_W = Q_W + FRAC_BITS;
  localparam int LAT   = NUM_W;

  // ---------------- configuration ----------------
  logic [H_W-1:0] half_r [3];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r[0] <= H_RESET;
      half_r[1] <= H_RESET;
      half_r[2] <= H_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_HALF_W: half_r[0] <= cfg_ch.data[H_W-1:0];
        REG_HALF_H: half_r[1] <= cfg_ch.data[H_W-1:0];
        REG_HALF_L: half_r[2] <= cfg_ch.data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  logic out_vld_r;
  logic en;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage A: numerators, divisors ----------------
  fx_t in_o [3];
  fx_t in_d [3];

  assign in_o[0] = in_ch.origin_x;
  assign in_o[1] = in_ch.origin_y;
  assign in_o[2] = in_ch.origin_z;
  assign in_d[0] = in_ch.dir_x;
  assign in_d[1] = in_ch.dir_y;
  assign in_d[2] = in_ch.dir_z;

  logic [Q_W-1:0] num_nxt [LANES];
  logic [Q_W-1:0] den_nxt [3];
  side_t          side_nxt;

  always_comb begin
    logic signed [Q_W+1:0] h_ext;
    logic signed [Q_W+1:0] o_ext;
    logic signed [Q_W+1:0] n_lo;
    logic signed [Q_W+1:0] n_hi;
    logic signed [Q_W+1:0] m_lo;
    logic signed [Q_W+1:0] m_hi;
    side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      h_ext = $signed({3'b000, half_r[i]});
      o_ext = $signed({{2{in_o[i][Q_W-1]}}, in_o[i]});
      n_lo  = -h_ext - o_ext;
      n_hi  = h_ext - o_ext;
      m_lo  = n_lo[Q_W+1] ? -n_lo : n_lo;
      m_hi  = n_hi[Q_W+1] ? -n_hi : n_hi;
      num_nxt[i]     = m_lo[Q_W-1:0];
      num_nxt[3 + i] = m_hi[Q_W-1:0];
      den_nxt[i]     = in_d[i][Q_W-1] ? (~in_d[i] + 1'b1) : in_d[i];
      side_nxt.o[i]  = in_o[i];
      side_nxt.d[i]  = in_d[i];
      side_nxt.fin[i] = (in_d[i] != '0);
      side_nxt.qneg[i]     = n_lo[Q_W+1] ^ in_d[i][Q_W-1];
      side_nxt.qneg[3 + i] = n_hi[Q_W+1] ^ in_d[i][Q_W-1];
      // zero direction with the origin outside that slab
      if ((in_d[i] == '0) && ((o_ext < -h_ext) || (o_ext > h_ext))) begin
        side_nxt.zmiss = 1'b1;
      end
    end
  end

  logic [Q_W-1:0] num_a_r [LANES];
  logic [Q_W-1:0] den_a_r [3];
  side_t          side_a_r;
  logic           vld_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r  <= num_nxt;
      den_a_r  <= den_nxt;
      side_a_r <= side_nxt;
    end
  end

  // ---------------- dividers ----------------
  logic [NUM_W-1:0] quo [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    rbsi_div #(
      .NUM_W (NUM_W),
      .DEN_W (Q_W)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i ({num_a_r[k], {FRAC_BITS{1'b0}}}),
      .den_i (den_a_r[k % 3]),
      .quo_o (quo[k])
    );
  end

  side_t          side_pipe_r [LAT];
  logic [LAT-1:0] vld_pipe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_pipe_r[0] <= side_a_r;
      for (int k = 1; k < LAT; k++) begin
        side_pipe_r[k] <= side_pipe_r[k-1];
      end
    end
  end

  // ---------------- stage 1: saturate, order crossings ----------------
  fx_t   tq [LANES];
  fx_t   lo_nxt [3];
  fx_t   hi_nxt [3];
  side_t side_q;

  assign side_q = side_pipe_r[LAT-1];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (side_q.qneg[k]) begin
        // magnitude above 2^31 pins to the most negative value
        if ((|quo[k][NUM_W-1:Q_W]) || (quo[k][Q_W-1] && (|quo[k][Q_W-2:0]))) begin
          tq[k] = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          tq[k] = -$signed(quo[k][Q_W-1:0]);
        end
      end else begin
        if (|quo[k][NUM_W-1:Q_W-1]) begin
          tq[k] = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          tq[k] = $signed(quo[k][Q_W-1:0]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (tq[i] > tq[3 + i]) begin
        lo_nxt[i] = tq[3 + i];
        hi_nxt[i] = tq[i];
      end else begin
        lo_nxt[i] = tq[i];
        hi_nxt[i] = tq[3 + i];
      end
    end
  end

  fx_t   lo_r [3];
  fx_t   hi_r [3];
  side_t side1_r;
  logic  vld1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      side1_r <= side_q;
    end
  end

  // ---------------- stage 2: interval, hit decision, normal axis ----------------
  fx_t   t_nxt;
  logic  hit_nxt;
  logic  inside_nxt;
  axis_t axis_nxt;

  always_comb begin
    fx_t  tmin;
    fx_t  tmax;
    logic any;
    tmin = '0;
    tmax = '0;
    any  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (side1_r.fin[i]) begin
        if (!any || (lo_r[i] > tmin)) tmin = lo_r[i];
        if (!any || (hi_r[i] < tmax)) tmax = hi_r[i];
        any = 1'b1;
      end
    end
    inside_nxt = 1'b0;
    t_nxt      = tmin;
    hit_nxt    = !side1_r.zmiss && any && !(tmax < tmin);
    if (tmin > 0) begin
      t_nxt = tmin;
    end else if ((tmin < 0) && (tmax > 0)) begin
      t_nxt      = tmax;
      inside_nxt = 1'b1;
    end else begin
      hit_nxt = 1'b0;
    end
    // y wins over z, z over x
    if (side1_r.fin[1] && ((t_nxt == lo_r[1]) || (t_nxt == hi_r[1]))) begin
      axis_nxt = AXIS_Y;
    end else if (side1_r.fin[2] && ((t_nxt == lo_r[2]) || (t_nxt == hi_r[2]))) begin
      axis_nxt = AXIS_Z;
    end else begin
      axis_nxt = AXIS_X;
    end
  end

  fx_t                 t2_r;
  logic                hit2_r;
  logic                inside2_r;
  axis_t               axis2_r;
  logic [2:0][Q_W-1:0] o2_r;
  logic [2:0][Q_W-1:0] d2_r;
  logic                vld2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r      <= t_nxt;
      hit2_r    <= hit_nxt;
      inside2_r <= inside_nxt;
      axis2_r   <= axis_nxt;
      o2_r      <= side1_r.o;
      d2_r      <= side1_r.d;
    end
  end

  // ---------------- stage 3: t * d ----------------
  logic signed [2*Q_W-1:0] prod_r [3];
  fx_t                     t3_r;
  logic                    hit3_r;
  logic                    inside3_r;
  axis_t                   axis3_r;
  logic [2:0][Q_W-1:0]     o3_r;
  logic                    vld3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= t2_r * $signed(d2_r[i]);
      end
      t3_r      <= t2_r;
      hit3_r    <= hit2_r;
      inside3_r <= inside2_r;
      axis3_r   <= axis2_r;
      o3_r      <= o2_r;
    end
  end

  // ---------------- stage 4: hit point, normal sign ----------------
  fx_t  p_nxt [3];
  logic neg_nxt;

  always_comb begin
    logic signed [2*Q_W-1:0] sh;
    logic signed [2*Q_W:0]   sum;
    fx_t                     p_sel;
    for (int i = 0; i < 3; i++) begin
      sh  = prod_r[i] >>> FRAC_BITS;
      sum = $signed({{(Q_W+1){o3_r[i][Q_W-1]}}, o3_r[i]}) + $signed({sh[2*Q_W-1], sh});
      if ((sum[2*Q_W:Q_W-1] == '0) || (sum[2*Q_W:Q_W-1] == '1)) begin
        p_nxt[i] = sum[Q_W-1:0];
      end else if (sum[2*Q_W]) begin
        p_nxt[i] = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
        p_nxt[i] = {1'b0, {(Q_W-1){1'b1}}};
      end
    end
    case (axis3_r)
      AXIS_Y:  p_sel = p_nxt[1];
      AXIS_Z:  p_sel = p_nxt[2];
      default: p_sel = p_nxt[0];
    endcase
    neg_nxt = (p_sel <= 0) ^ inside3_r;
  end

  logic           hit_r;
  logic [H_W-1:0] distance_r;
  fx_t            point_r [3];
  axis_t          axis_r;
  logic           neg_r;
  logic           inside_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r      <= hit3_r;
      distance_r <= hit3_r ? t3_r[H_W-1:0] : '0;
      for (int i = 0; i < 3; i++) begin
        point_r[i] <= hit3_r ? p_nxt[i] : '0;
      end
      axis_r     <= hit3_r ? axis3_r : AXIS_X;
      neg_r      <= hit3_r && neg_nxt;
      inside_r   <= hit3_r && inside3_r;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r    <= 1'b0;
      vld_pipe_r <= '0;
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      vld3_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      vld_a_r    <= in_ch.valid;
      vld_pipe_r <= {vld_pipe_r[LAT-2:0], vld_a_r};
      vld1_r     <= vld_pipe_r[LAT-1];
      vld2_r     <= vld1_r;
      vld3_r     <= vld2_r;
      out_vld_r  <= vld3_r;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.hit             = hit_r;
  assign out_ch.distance        = distance_r;
  assign out_ch.point_x         = point_r[0];
  assign out_ch.point_y         = point_r[1];
  assign out_ch.point_z         = point_r[2];
  assign out_ch.normal_axis     = axis_r;
  assign out_ch.normal_negative = neg_r;
  assign out_ch.from_inside     = inside_r;

  // ---------------- assertions ----------------
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !hit_r |-> (distance_r == '0) && (axis_r == AXIS_X) && !neg_r && !inside_r)
    else $error("miss result carries nonzero fields");

  a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && inside_r |-> hit_r)
    else $error("exit flagged without a hit");

  a_entry_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && hit_r && !inside_r |-> (distance_r != '0))
    else $error("entry hit at zero distance");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_pipe_r) && $stable(vld3_r) && $stable(vld_a_r))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
